// File: rtl/core/poil_pkg.sv
// ----------------------------------------------------------------------------
// poil_pkg
// Shared types, codes and helpers of the packed offset index lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package poil_pkg;

	localparam int TABLE_DEPTH_DEF = 4096;
	localparam int ID_W            = 40;
	localparam int OFF_W           = 40;
	localparam int BYTES_W         = 3;
	localparam int CFG_ADDR_W      = 2;
	localparam int CFG_DATA_W      = 40;

	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FOUND   = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_KEY_BYTES    = 2'd0,
		CFG_OFFSET_BYTES = 2'd1,
		CFG_DATA_LENGTH  = 2'd2
	} cfg_idx_t;

	// Keep the low nbytes bytes; zero acts as one byte, six and seven as five.
	function automatic logic [ID_W-1:0] byte_mask(input logic [BYTES_W-1:0] nbytes);
		logic [ID_W-1:0] m;
		case (nbytes)
			3'd0, 3'd1: m = 40'h00_0000_00FF;
			3'd2:       m = 40'h00_0000_FFFF;
			3'd3:       m = 40'h00_00FF_FFFF;
			3'd4:       m = 40'h00_FFFF_FFFF;
			default:    m = 40'hFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/poil_ram.sv
// ----------------------------------------------------------------------------
// poil_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module poil_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/packed_offset_index_lookup_unit.sv
// ----------------------------------------------------------------------------
// packed_offset_index_lookup_unit
// Sorted (id, offset) table with a lower-bound binary search lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input transfers on s_*: s_tuser carries the mode (load, lookup, clear),
//   s_tdata the key and the entry offset. Every accepted item yields exactly
//   one result transfer on m_*: m_tuser is the status, m_tdata the range.
//   The user must write the registers through cfg_we/cfg_addr/cfg_wdata while
//   idle; the block itself does not enforce it. Timing: one item is worked at a
//   time; s_tready is high only when the sequencer is idle. A load, clear or unused
//   mode goes from acceptance to the done state, and from there to the output
//   register once it is free. A lookup runs one probe of the id RAM per cycle,
//   up to floor(log2(entry count)) + 1 probes, then the match state and, when
//   the entry is not the last, the next state with one more read for the range
//   end, then the done state. The id/offset RAM read port sets the probe rate.
//   A finished result sits in the output register while the next item is
//   accepted; if the receiver stalls and a second result is ready, the
//   sequencer holds it and s_tready stays low until the output register frees.
//   Reset clears the entry count, the registers to their defaults and the
//   output valid; table contents are left as they are, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_offset_index_lookup_unit #(
	parameter int TABLE_DEPTH = poil_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration
	input  wire logic                             cfg_we,
	input  wire logic [poil_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [poil_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// input stream
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [79:0]                      s_tdata,  // [39:0] key, [79:40] entry_offset
	input  wire logic [1:0]                       s_tuser,  // [1:0] mode
	// result stream
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [79:0]                      m_tdata,  // [39:0] range_start, [79:40] range_end
	output logic      [1:0]                       m_tuser   // [1:0] status
);

	import poil_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE,
		S_MATCH,
		S_NEXT,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       n_q;
	logic [ID_W-1:0]     key_q;
	logic [BYTES_W-1:0]  key_bytes_q;
	logic [BYTES_W-1:0]  offset_bytes_q;
	logic [OFF_W-1:0]    data_length_q;
	status_t             res_status_q;
	logic [OFF_W-1:0]    res_start_q;
	logic [OFF_W-1:0]    res_end_q;

	logic                accept;
	mode_t               in_mode;
	logic [ID_W-1:0]     in_key;
	logic [OFF_W-1:0]    in_off;
	logic                ram_we;
	logic [AW-1:0]       raddr;
	logic [ID_W-1:0]     id_rdata;
	logic [OFF_W-1:0]    off_rdata;
	logic [ID_W-1:0]     id_m;
	logic [OFF_W-1:0]    off_m;
	logic [CW-1:0]       half;
	logic                id_lt;
	logic [CW-1:0]       lo_nx;
	logic [CW-1:0]       n_nx;
	logic [CW-1:0]       probe_nx;
	logic [CW-1:0]       lo_inc;
	logic                out_free;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_mode  = mode_t'(s_tuser);
	assign in_key   = s_tdata[39:0];
	assign in_off   = s_tdata[79:40];
	assign ram_we   = accept && (in_mode == MODE_LOAD) && (count_q < DEPTH_C);
	assign out_free = !m_tvalid || m_tready;

	// Shared probe step: one masked compare and the lower-bound update.
	assign id_m     = id_rdata & byte_mask(key_bytes_q);
	assign off_m    = off_rdata & byte_mask(offset_bytes_q);
	assign half     = n_q >> 1;
	assign id_lt    = id_m < key_q;
	assign lo_nx    = id_lt ? CW'(lo_q + half + CW'(1)) : lo_q;
	assign n_nx     = id_lt ? CW'(n_q - half - CW'(1)) : half;
	assign probe_nx = CW'(lo_nx + (n_nx >> 1));
	assign lo_inc   = CW'(lo_q + CW'(1));

	// When the search closes (n_nx zero) the address is lo itself: the match read.
	always_comb begin
		case (state_q)
			S_IDLE:  raddr = AW'(count_q >> 1);
			S_PROBE: raddr = probe_nx[AW-1:0];
			S_MATCH: raddr = lo_inc[AW-1:0];
			default: raddr = '0;
		endcase
	end

	poil_ram #(.WIDTH(ID_W), .DEPTH(TABLE_DEPTH)) u_id_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (in_key),
		.raddr (raddr),
		.rdata (id_rdata)
	);

	poil_ram #(.WIDTH(OFF_W), .DEPTH(TABLE_DEPTH)) u_off_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (in_off),
		.raddr (raddr),
		.rdata (off_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			lo_q           <= '0;
			n_q            <= '0;
			key_q          <= '0;
			key_bytes_q    <= 3'd4;
			offset_bytes_q <= 3'd4;
			data_length_q  <= '0;
			res_status_q   <= ST_DONE;
			res_start_q    <= '0;
			res_end_q      <= '0;
			m_tvalid       <= 1'b0;
			m_tdata        <= '0;
			m_tuser        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_KEY_BYTES:    key_bytes_q    <= cfg_wdata[BYTES_W-1:0];
					CFG_OFFSET_BYTES: offset_bytes_q <= cfg_wdata[BYTES_W-1:0];
					CFG_DATA_LENGTH:  data_length_q  <= cfg_wdata[OFF_W-1:0];
					default: ;
				endcase
			end

			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q        <= in_key;
						lo_q         <= '0;
						n_q          <= count_q;
						res_status_q <= ST_DONE;
						res_start_q  <= '0;
						res_end_q    <= '0;
						state_q      <= S_DONE;
						case (in_mode)
							MODE_LOAD: begin
								if (count_q < DEPTH_C) begin
									count_q <= CW'(count_q + CW'(1));
								end else begin
									res_status_q <= ST_FULL;
								end
							end
							MODE_LOOKUP: begin
								if (count_q == '0) begin
									res_status_q <= ST_MISSING;
								end else begin
									state_q <= S_PROBE;
								end
							end
							MODE_CLEAR: count_q <= '0;
							default: ;
						endcase
					end
				end
				S_PROBE: begin
					lo_q <= lo_nx;
					n_q  <= n_nx;
					if (n_nx == '0) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					if ((lo_q < count_q) && (id_m == key_q)) begin
						res_status_q <= ST_FOUND;
						res_start_q  <= off_m;
						if (lo_inc < count_q) begin
							state_q <= S_NEXT;
						end else begin
							res_end_q <= data_length_q;
							state_q   <= S_DONE;
						end
					end else begin
						res_status_q <= ST_MISSING;
						state_q      <= S_DONE;
					end
				end
				S_NEXT: begin
					res_end_q <= off_m;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					// hold the result until the output register frees
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {res_end_q, res_start_q};
						m_tuser  <= res_status_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/poil_checker.sv
// ----------------------------------------------------------------------------
// poil_checker
// Port-level checks of the packed offset index lookup unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module poil_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [79:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	import poil_pkg::*;

	// A stalled result transfer holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only a found result carries a range.
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_FOUND) |-> (m_tdata == '0))
		else $error("range nonzero on a result that is not found");

	// One item at a time: after a transfer the sequencer is busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transfer");

	// A load, clear or unused mode accepted while the output is not stalled
	// passes the done state and shows a valid result.
	a_short_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != MODE_LOOKUP) && !(m_tvalid && !m_tready)
		|=> ##1 m_tvalid)
		else $error("short item result missing");

endmodule

bind packed_offset_index_lookup_unit poil_checker u_poil_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// File: bench/packed_offset_index_lookup_unit_test.sv
// ----------------------------------------------------------------------------
// packed_offset_index_lookup_unit_test
// Drives loads, lookups and clears into the offset index table with random
// gaps and output stalls. A shadow copy of the table, of the entry count and
// of the registers predicts each range result, and every result transfer is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module packed_offset_index_lookup_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import poil_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 1840;
	localparam int SETTLE_CYCLES = 24;  // longest lookup plus margin

	typedef struct {
		logic [1:0]  status;
		logic [39:0] start;
		logic [39:0] stop;
	} span_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [79:0] s_tdata = '0;  // [39:0] key, [79:40] entry_offset
	logic [1:0] s_tuser = '0;   // [1:0] mode
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [79:0] m_tdata;       // [39:0] range_start, [79:40] range_end
	logic [1:0] m_tuser;        // [1:0] status

	// shadow of the block
	logic [39:0] id_shadow [DEPTH];
	logic [39:0] off_shadow [DEPTH];
	int entries = 0;
	logic [2:0] kb_shadow = 3'd4;
	logic [2:0] ob_shadow = 3'd4;
	logic [39:0] len_shadow = '0;

	span_t span_q[$];
	int mismatches = 0;
	int items_sent = 0;
	bit steady = 1'b0;
	int unsigned ready_run = 0;

	packed_offset_index_lookup_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [39:0] rand40();
		return 40'({$urandom(), $urandom()});
	endfunction

	// Keep the low bytes; zero counts as one byte, six and seven as five.
	function automatic logic [39:0] low_bytes(input logic [39:0] v, input logic [2:0] nb);
		logic [39:0] r;
		int n;
		r = '0;
		n = (nb == 3'd0) ? 1 : (nb > 3'd5) ? 5 : int'(nb);
		for (int b = 0; b < n; b++)
			r[8*b +: 8] = v[8*b +: 8];
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void predict_span(input logic [1:0] mode, input logic [39:0] key,
			input logic [39:0] eoff);
		span_t r;
		int lo;
		int n;
		int half;
		r = '{ST_DONE, '0, '0};
		case (mode)
			MODE_LOAD: begin
				if (entries >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					id_shadow[entries] = key;
					off_shadow[entries] = eoff;
					entries++;
				end
			end
			MODE_LOOKUP: begin
				// lower bound over truncated ids, key compared in full
				lo = 0;
				n = entries;
				while (n > 0) begin
					half = n / 2;
					if (low_bytes(id_shadow[lo + half], kb_shadow) < key) begin
						lo = lo + half + 1;
						n = n - half - 1;
					end else begin
						n = half;
					end
				end
				if (lo < entries && low_bytes(id_shadow[lo], kb_shadow) == key) begin
					r.status = ST_FOUND;
					r.start = low_bytes(off_shadow[lo], ob_shadow);
					r.stop = (lo + 1 < entries) ? low_bytes(off_shadow[lo + 1], ob_shadow)
						: len_shadow;
				end else begin
					r.status = ST_MISSING;
				end
			end
			MODE_CLEAR: begin
				entries = 0;
			end
			default: ;
		endcase
		span_q.insert(span_q.size(), r);
	endfunction

	// Receiver: random runs of ready and stall, always ready in steady stretches.
	always @(posedge clk) begin
		if (steady) begin
			m_tready <= 1'b1;
			ready_run <= 0;
		end else if (ready_run != 0) begin
			ready_run <= ready_run - 1;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
			ready_run <= pick_gap();
		end
	end

	always @(posedge clk) begin : check_results
		span_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (span_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result: st %0d start %h end %h", $time,
						m_tuser, m_tdata[39:0], m_tdata[79:40]);
			end else begin
				want = span_q[0];
				span_q.delete(0);
				if (m_tuser !== want.status || m_tdata[39:0] !== want.start
						|| m_tdata[79:40] !== want.stop) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] mismatch: st %0d exp %0d, start %h exp %h, end %h exp %h",
							$time, m_tuser, want.status, m_tdata[39:0], want.start,
							m_tdata[79:40], want.stop);
				end
			end
		end
	end

	task automatic push_item(input logic [1:0] mode, input logic [39:0] key,
			input logic [39:0] eoff);
		int unsigned gap;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {eoff, key};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_span(mode, key, eoff);
		if (mode != MODE_SPARE)
			items_sent++;
	endtask

	// Drop valid and wait until every pending result has been seen.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (span_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [2:0] kb, input logic [2:0] ob,
			input logic [39:0] len, input bit poke_spare);
		logic [CFG_ADDR_W-1:0] addr [4];
		logic [39:0] data [4];
		int cnt;
		settle();
		// junk above the three live bits of the byte counts
		addr[0] = CFG_KEY_BYTES;
		data[0] = (rand40() & ~40'h7) | 40'(kb);
		addr[1] = CFG_OFFSET_BYTES;
		data[1] = (rand40() & ~40'h7) | 40'(ob);
		addr[2] = CFG_DATA_LENGTH;
		data[2] = len;
		addr[3] = CFG_SPARE;
		data[3] = rand40();
		cnt = poke_spare ? 4 : 3;
		for (int i = 0; i < cnt; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= addr[i];
			cfg_wdata <= data[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		kb_shadow = kb;
		ob_shadow = ob;
		len_shadow = len;
	endtask

	task automatic test_directed();
		push_item(MODE_CLEAR, rand40(), rand40());
		push_item(MODE_LOOKUP, '0, '0);                   // empty table
		push_item(MODE_SPARE, '1, '1);
		push_item(MODE_LOAD, 40'h0, 40'h0);              // zero offset is still found
		push_item(MODE_LOAD, 40'h5, 40'h12_3456_7890);
		push_item(MODE_LOAD, 40'h01_0000_0007, 40'h10);   // truncates under reset widths
		push_item(MODE_LOAD, '1, '1);
		push_item(MODE_LOOKUP, 40'h0, rand40());
		push_item(MODE_LOOKUP, 40'h5, rand40());          // range end below start
		push_item(MODE_LOOKUP, 40'h7, '0);
		push_item(MODE_LOOKUP, 40'h01_0000_0007, '0);     // key compares in full
		push_item(MODE_LOOKUP, 40'hFFFF_FFFF, '0);        // last entry ends at data length
		push_item(MODE_LOOKUP, '1, '1);
		push_item(MODE_LOOKUP, 40'h6, '0);
		push_item(MODE_LOAD, 40'h3, 40'h2);               // out of order
		push_item(MODE_LOOKUP, 40'h3, '0);
		push_item(MODE_LOOKUP, 40'h7, '0);
		push_item(MODE_CLEAR, '0, '0);
		push_item(MODE_LOOKUP, 40'h5, '0);
		push_item(MODE_LOAD, 40'h5, 40'h8);
		push_item(MODE_LOOKUP, 40'h5, '0);
	endtask

	task automatic test_register_sweep();
		logic [39:0] mask;
		logic [39:0] ids [4];
		logic [39:0] len;
		for (int kb = 0; kb < 8; kb++) begin
			case (kb % 3)
				0: len = '0;
				1: len = '1;
				default: len = rand40();
			endcase
			program_regs(3'(kb), 3'(7 - kb), len, kb == 3);
			steady = kb[0];
			mask = low_bytes('1, 3'(kb));
			ids[0] = 40'h0;
			ids[1] = 40'h1;
			ids[2] = mask - 1;
			ids[3] = mask;
			push_item(MODE_CLEAR, rand40(), rand40());
			push_item(MODE_LOAD, ids[0] | (rand40() & ~mask), '1);
			push_item(MODE_LOAD, ids[1] | (rand40() & ~mask), rand40());
			push_item(MODE_LOAD, ids[2] | (rand40() & ~mask), '0);
			push_item(MODE_LOAD, ids[3] | ~mask, rand40());
			for (int i = 0; i < 4; i++)
				push_item(MODE_LOOKUP, ids[i], rand40());
			push_item(MODE_LOOKUP, mask + 1, rand40());
			push_item(MODE_LOOKUP, 40'h2, rand40());
		end
		steady = 1'b0;
	endtask

	task automatic test_random_sessions();
		logic [39:0] raw_ids[$];
		logic [39:0] mask;
		logic [39:0] key;
		logic [39:0] len;
		longint unsigned cur;
		int goal;
		int n_load;
		int n_look;
		int pick;
		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			if ($urandom_range(0, 3) == 0) begin
				pick = $urandom_range(0, 9);
				len = (pick == 0) ? '0 : (pick == 1) ? '1 : rand40();
				program_regs(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), len,
					$urandom_range(0, 7) == 0);
			end
			steady = ($urandom_range(0, 4) == 0);
			raw_ids.delete();
			push_item(MODE_CLEAR, rand40(), rand40());
			mask = low_bytes('1, kb_shadow);
			n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300)
				: $urandom_range(1, 24);
			if ($urandom_range(0, 3) == 0 && longint'(mask) > 4 * n_load)
				cur = longint'(mask) - 3 * n_load;
			else
				cur = $urandom_range(0, 16);
			// ascending truncated ids with random upper bytes, a few duplicates
			for (int i = 0; i < n_load && cur <= longint'(mask); i++) begin
				key = 40'(cur) | (rand40() & ~mask);
				if ($urandom_range(0, 24) == 0)
					key = rand40();
				raw_ids.insert(raw_ids.size(), key);
				push_item(MODE_LOAD, key, rand40());
				cur += $urandom_range(0, 5);
			end
			if ($urandom_range(0, 6) == 0) begin
				pick = $urandom_range(0, 9);
				len = (pick == 0) ? '0 : (pick == 1) ? '1 : rand40();
				program_regs(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), len,
					1'b0);
			end
			n_look = $urandom_range(1, 2 * raw_ids.size() + 2);
			for (int i = 0; i < n_look; i++) begin
				pick = $urandom_range(0, 99);
				key = low_bytes(raw_ids[$urandom_range(0, raw_ids.size() - 1)], kb_shadow);
				if (pick < 65) begin
					push_item(MODE_LOOKUP, key, rand40());
				end else if (pick < 80) begin
					push_item(MODE_LOOKUP, low_bytes(rand40(), kb_shadow), rand40());
				end else if (pick < 87) begin
					push_item(MODE_LOOKUP, rand40(), rand40());
				end else if (pick < 93) begin
					push_item(MODE_LOOKUP, key + 1, rand40());
				end else if (pick < 96) begin
					push_item(MODE_SPARE, rand40(), rand40());
				end else if (pick < 99) begin
					key = rand40();
					raw_ids.insert(raw_ids.size(), key);
					push_item(MODE_LOAD, key, rand40());
				end else begin
					push_item(MODE_CLEAR, rand40(), rand40());
				end
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_sweep();
		test_random_sessions();
		settle();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("status: fail");
		$finish;
	end

endmodule
